### hdl/cial_pkg.sv
// shared types and constants of the circular index point list
package cial_pkg;

  localparam int CAPACITY = 8;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 16;
  localparam int COORD_W  = 32;
  localparam int ENT_W    = 4;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_GET    = 2'd2,
    KIND_SET    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAP,
    S_MOVE_RD,
    S_MOVE_WR,
    S_PUT,
    S_GET_RD,
    S_GET_WAIT,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
  } point_t;

  // request to the slot mapping unit
  typedef struct packed {
    logic             start;
    logic             neg;
    logic [POS_W-1:0] mag;
    logic [CNT_W-1:0] n;
  } map_req_t;

  // answer from the slot mapping unit
  typedef struct packed {
    logic             done;
    logic [IDX_W-1:0] slot;
  } map_rsp_t;

endpackage

### hdl/cial_ram.sv
// generic single write, single read ram with registered read data
module cial_ram #(
  parameter int WIDTH  = 96,
  parameter int DEPTH  = 8,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### hdl/cial_slot_map.sv
// bit-serial modulo unit that maps a signed position onto a live slot
module cial_slot_map (
  input  logic              clk,
  input  logic              rst,
  input  cial_pkg::map_req_t req,
  output cial_pkg::map_rsp_t rsp
);
  import cial_pkg::*;

  localparam int STEP_W = $clog2(POS_W);

  logic              busy;
  logic              done;
  logic              neg;
  logic [CNT_W-1:0]  n;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  rem_next;
  logic [POS_W-1:0]  dvd;
  logic [STEP_W-1:0] step;
  logic [CNT_W:0]    trial;
  logic [CNT_W-1:0]  slot_full;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial = {rem, dvd[POS_W-1]};
    if (trial >= {1'b0, n}) begin
      rem_next = CNT_W'(trial - {1'b0, n});
    end else begin
      rem_next = trial[CNT_W-1:0];
    end
  end

  // iteration control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      if (req.start) begin
        busy <= 1'b1;
        done <= 1'b0;
      end else if (busy && step == STEP_W'(POS_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        done <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem  <= '0;
      dvd  <= req.mag;
      neg  <= req.neg;
      n    <= req.n;
      step <= '0;
    end else if (busy) begin
      rem  <= rem_next;
      dvd  <= {dvd[POS_W-2:0], 1'b0};
      step <= step + 1'b1;
    end
  end

  // negative positions count back from the end, a multiple of n lands on slot 0
  always_comb begin
    if (neg && rem != '0) begin
      slot_full = n - rem;
    end else begin
      slot_full = rem;
    end
  end

  assign rsp.done = done;
  assign rsp.slot = slot_full[IDX_W-1:0];

endmodule

### hdl/circular_index_array_list_unit.sv
// top level of the circular index point list
// A bounded list of up to CAPACITY points held in one ram of whole points.
// Requests are handled one at a time. A refused request (insert into a full
// list, any other kind on an empty list) goes straight to the result state.
// Every other request first maps its position through a bit-serial modulo unit
// that works through the position bits one at a time. Get then reads the slot
// in a read state and a wait state for the registered ram read, set writes it
// in the put state, and insert and delete move each shifted entry with a read
// state and a write state through the single ram port pair; insert then puts
// the new point. Insert into an empty list skips the mapping. The result sits
// in an output register, so the next request is accepted while it waits to be
// taken.
module circular_index_array_list_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [1:0]                           kind,
  input  logic signed [cial_pkg::POS_W-1:0]    position,
  input  logic signed [cial_pkg::COORD_W-1:0]  coord_x,
  input  logic signed [cial_pkg::COORD_W-1:0]  coord_y,
  input  logic signed [cial_pkg::COORD_W-1:0]  coord_z,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [cial_pkg::COORD_W-1:0]  read_x,
  output logic signed [cial_pkg::COORD_W-1:0]  read_y,
  output logic signed [cial_pkg::COORD_W-1:0]  read_z,
  output logic [1:0]                           status,
  output logic [cial_pkg::ENT_W-1:0]           entries
);
  import cial_pkg::*;

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [1:0]       op_kind;
  point_t           op_point;
  logic [IDX_W-1:0] slot;
  logic [IDX_W-1:0] cursor;
  point_t           res_point;
  logic [1:0]       res_status;

  logic             accept;
  logic             full;
  logic             empty;
  logic             more;
  logic             resp_load;
  logic [POS_W-1:0] mag;
  logic             map_start;

  map_req_t         map_req;
  map_rsp_t         map_rsp;

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  point_t           wr_data;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  point_t           rd_data;

  assign accept    = in_valid && in_ready;
  assign full      = count >= CNT_W'(CAPACITY);
  assign empty     = count == '0;
  assign resp_load = (state == S_RESP) && (!out_valid || out_ready);

  // another entry to shift: upward for insert, downward for delete
  always_comb begin
    if (op_kind == KIND_INSERT) begin
      more = cursor > slot;
    end else begin
      more = (CNT_W'(cursor) + 1'b1) < count;
    end
  end

  // magnitude of the position for the modulo unit
  assign mag = position[POS_W-1] ? POS_W'(~position + 1'b1) : POS_W'(position);

  assign map_req = '{start: map_start, neg: position[POS_W-1], mag: mag, n: count};

  cial_slot_map u_map (
    .clk (clk),
    .rst (rst),
    .req (map_req),
    .rsp (map_rsp)
  );

  cial_ram #(
    .WIDTH ($bits(point_t)),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (kind == KIND_INSERT) begin
            if (full) begin
              state_next = S_RESP;
            end else if (empty) begin
              state_next = S_PUT;
            end else begin
              state_next = S_MAP;
            end
          end else if (empty) begin
            state_next = S_RESP;
          end else begin
            state_next = S_MAP;
          end
        end
      end
      S_MAP: begin
        if (map_rsp.done) begin
          unique case (op_kind)
            KIND_INSERT, KIND_DELETE: state_next = S_MOVE_RD;
            KIND_GET:                 state_next = S_GET_RD;
            default:                  state_next = S_PUT;
          endcase
        end
      end
      S_MOVE_RD: begin
        if (more) begin
          state_next = S_MOVE_WR;
        end else if (op_kind == KIND_INSERT) begin
          state_next = S_PUT;
        end else begin
          state_next = S_RESP;
        end
      end
      S_MOVE_WR:  state_next = S_MOVE_RD;
      S_PUT:      state_next = S_RESP;
      S_GET_RD:   state_next = S_GET_WAIT;
      S_GET_WAIT: state_next = S_RESP;
      S_RESP: begin
        if (resp_load) begin
          state_next = S_IDLE;
        end
      end
      default:    state_next = S_IDLE;
    endcase
  end

  // control outputs and ram access
  always_comb begin
    in_ready  = 1'b0;
    map_start = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = slot;
    wr_en     = 1'b0;
    wr_addr   = cursor;
    wr_data   = rd_data;
    unique case (state)
      S_IDLE: begin
        in_ready  = 1'b1;
        map_start = in_valid && !empty && !(kind == KIND_INSERT && full);
      end
      S_MOVE_RD: begin
        rd_en   = more;
        rd_addr = (op_kind == KIND_INSERT) ? cursor - 1'b1 : cursor + 1'b1;
      end
      S_MOVE_WR: begin
        wr_en = 1'b1;
      end
      S_PUT: begin
        wr_en   = 1'b1;
        wr_addr = slot;
        wr_data = op_point;
      end
      S_GET_RD: begin
        rd_en = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // count after the request
  always_comb begin
    count_next = count;
    if (res_status == ST_DONE) begin
      if (op_kind == KIND_INSERT) begin
        count_next = count + 1'b1;
      end else if (op_kind == KIND_DELETE) begin
        count_next = count - 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (resp_load) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // request datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      op_kind    <= kind;
      op_point   <= '{x: coord_x, y: coord_y, z: coord_z};
      slot       <= '0;
      res_point  <= '0;
      if (kind == KIND_INSERT && full) begin
        res_status <= ST_FULL;
      end else if (kind != KIND_INSERT && empty) begin
        res_status <= ST_EMPTY;
      end else begin
        res_status <= ST_DONE;
      end
    end
    if (state == S_MAP && map_rsp.done) begin
      slot <= map_rsp.slot;
      if (op_kind == KIND_INSERT) begin
        cursor <= count[IDX_W-1:0];
      end else begin
        cursor <= map_rsp.slot;
      end
    end
    if (state == S_MOVE_WR) begin
      if (op_kind == KIND_INSERT) begin
        cursor <= cursor - 1'b1;
      end else begin
        cursor <= cursor + 1'b1;
      end
    end
    if (state == S_GET_WAIT) begin
      res_point <= rd_data;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (resp_load) begin
      read_x  <= res_point.x;
      read_y  <= res_point.y;
      read_z  <= res_point.z;
      status  <= res_status;
      entries <= ENT_W'(count_next);
    end
  end

  // the list never holds more than its capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("point count above capacity");

  // writes stay inside the live list plus the slot an insert opens
  a_write_range: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> CNT_W'(wr_addr) <= count)
    else $error("ram write beyond the list");

  // the modulo unit only finishes while a mapping is awaited
  a_map_done: assert property (@(posedge clk) disable iff (rst)
    map_rsp.done |-> state == S_MAP)
    else $error("slot map finished outside mapping");

  // an accepted request blocks the input until its result is formed
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("request accepted while another is in flight");

endmodule

### tb/sv/list_checker.sv
// checker for the circular index point list: predicts each result and compares it
`timescale 1ns / 1ps

module list_checker (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  input  logic                                 in_ready,
  input  logic [1:0]                           kind,
  input  logic signed [cial_pkg::POS_W-1:0]    position,
  input  logic signed [cial_pkg::COORD_W-1:0]  coord_x,
  input  logic signed [cial_pkg::COORD_W-1:0]  coord_y,
  input  logic signed [cial_pkg::COORD_W-1:0]  coord_z,
  input  logic                                 out_valid,
  input  logic                                 out_ready,
  input  logic signed [cial_pkg::COORD_W-1:0]  read_x,
  input  logic signed [cial_pkg::COORD_W-1:0]  read_y,
  input  logic signed [cial_pkg::COORD_W-1:0]  read_z,
  input  logic [1:0]                           status,
  input  logic [cial_pkg::ENT_W-1:0]           entries,
  output int                                   fail_count,
  output int                                   pending
);
  import cial_pkg::*;

  typedef struct packed {
    point_t            pt;
    status_t           st;
    logic [ENT_W-1:0]  ent;
  } outcome_t;

  // shadow copy of the list
  point_t   held_points [CAPACITY];
  int       held;
  outcome_t awaited_results [$];

  initial begin
    fail_count = 0;
    pending    = 0;
    held       = 0;
  end

  // wrap a signed position onto a live list of n points
  function automatic int slot_of(logic signed [POS_W-1:0] pos, int n);
    int mag;
    int rem;
    if (pos < 0) begin
      mag = -int'(pos);
      rem = mag % n;
      return (rem == 0) ? 0 : n - rem;
    end
    return int'(pos) % n;
  endfunction

  // apply one request to the shadow list and return what the block should answer
  function automatic outcome_t list_outcome(kind_t k, logic signed [POS_W-1:0] pos,
                                            point_t pt);
    outcome_t res;
    int       slot;
    res    = '0;
    res.st = ST_DONE;
    if (k == KIND_INSERT) begin
      if (held >= CAPACITY) begin
        res.st = ST_FULL;
      end else begin
        slot = (held == 0) ? 0 : slot_of(pos, held);
        for (int i = held; i > slot; i--) held_points[i] = held_points[i-1];
        held_points[slot] = pt;
        held++;
      end
    end else if (held == 0) begin
      res.st = ST_EMPTY;
    end else begin
      slot = slot_of(pos, held);
      case (k)
        KIND_DELETE: begin
          for (int i = slot; i + 1 < held; i++) held_points[i] = held_points[i+1];
          held--;
        end
        KIND_GET: res.pt = held_points[slot];
        default: held_points[slot] = pt;
      endcase
    end
    res.ent = ENT_W'(held);
    return res;
  endfunction

  // report one field, returns 1 on a mismatch
  function automatic int field_diff(string name, logic [COORD_W-1:0] want,
                                    logic [COORD_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  // results are checked before the request of the same edge is queued
  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      awaited_results.delete();
      held = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h %h %h %h %h",
                   $time, read_x, read_y, read_z, status, entries);
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          fail_count += field_diff("read_x", want.pt.x, read_x);
          fail_count += field_diff("read_y", want.pt.y, read_y);
          fail_count += field_diff("read_z", want.pt.z, read_z);
          fail_count += field_diff("status", COORD_W'(want.st), COORD_W'(status));
          fail_count += field_diff("entries", COORD_W'(want.ent), COORD_W'(entries));
        end
      end
      if (in_valid && in_ready)
        awaited_results.push_back(list_outcome(kind_t'(kind), position,
                                               point_t'{coord_x, coord_y, coord_z}));
    end
    pending = awaited_results.size();
  end

endmodule

### tb/sv/tb_top.sv
// top of the point list testbench: clock, reset, request stimulus and verdict
`timescale 1ns / 1ps

module tb_top;
  import cial_pkg::*;

  typedef enum int {
    MIX_GROW,
    MIX_SHRINK,
    MIX_EVEN
  } mix_t;

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       in_valid;
  logic                       in_ready;
  kind_t                      req_kind;
  logic signed [POS_W-1:0]    position;
  logic signed [COORD_W-1:0]  coord_x;
  logic signed [COORD_W-1:0]  coord_y;
  logic signed [COORD_W-1:0]  coord_z;
  logic                       out_valid;
  logic                       out_ready;
  logic signed [COORD_W-1:0]  read_x;
  logic signed [COORD_W-1:0]  read_y;
  logic signed [COORD_W-1:0]  read_z;
  logic [1:0]                 status;
  logic [ENT_W-1:0]           entries;
  int                         fail_count;
  int                         pending;
  int                         gap_max;

  always #2 clk = ~clk;

  circular_index_array_list_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (req_kind),
    .position  (position),
    .coord_x   (coord_x),
    .coord_y   (coord_y),
    .coord_z   (coord_z),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .read_x    (read_x),
    .read_y    (read_y),
    .read_z    (read_z),
    .status    (status),
    .entries   (entries)
  );

  list_checker chk (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .kind       (req_kind),
    .position   (position),
    .coord_x    (coord_x),
    .coord_y    (coord_y),
    .coord_z    (coord_z),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .read_x     (read_x),
    .read_y     (read_y),
    .read_z     (read_z),
    .status     (status),
    .entries    (entries),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // random coordinate, with the corner values now and then
  function automatic logic [COORD_W-1:0] pick_coord();
    if ($urandom_range(0, 7) != 0) return $urandom;
    case ($urandom_range(0, 3))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      default: return 32'hffff_ffff;
    endcase
  endfunction

  // present one request after a random gap, return after it is taken
  task automatic issue_request(kind_t k, logic signed [POS_W-1:0] pos,
                               logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                               logic [COORD_W-1:0] z);
    int gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_kind <= k;
    position <= pos;
    coord_x  <= x;
    coord_y  <= y;
    coord_z  <= z;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // hold off the sender until every result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // result side: random stalls with stretches of none
  initial begin
    int   stall;
    logic rx_fast;
    out_ready = 1'b0;
    rx_fast   = 1'b0;
    @(negedge rst);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 29) == 0) rx_fast = !rx_fast;
      stall = rx_fast ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      @(negedge clk);
    end
  end

  // request stimulus and verdict
  initial begin
    mix_t                     mix;
    kind_t                    k;
    logic signed [POS_W-1:0]  pos;
    int                       roll;
    rst      = 1'b1;
    in_valid = 1'b0;
    req_kind = KIND_GET;
    position = '0;
    coord_x  = '0;
    coord_y  = '0;
    coord_z  = '0;
    gap_max  = 19;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // accesses on the empty list are refused
    issue_request(KIND_GET, 16'sd0, 32'h1, 32'h2, 32'h3);
    issue_request(KIND_DELETE, -16'sd1, 32'h0, 32'h0, 32'h0);
    issue_request(KIND_SET, 16'sh7fff, 32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    // first insert lands in slot 0 whatever the position
    issue_request(KIND_INSERT, 16'sh8000, 32'h8000_0000, 32'h7fff_ffff, 32'h0);
    issue_request(KIND_INSERT, 16'sh7fff, 32'hffff_ffff, 32'h0, 32'h8000_0000);
    issue_request(KIND_INSERT, -16'sd1, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff);
    issue_request(KIND_INSERT, 16'sh8000, 32'h1234_5678, 32'h9abc_def0, 32'h0f0f_0f0f);
    issue_request(KIND_INSERT, 16'sd0, 32'h0, 32'hffff_ffff, 32'h7fff_ffff);
    issue_request(KIND_INSERT, -16'sd4, 32'h5555_5555, 32'haaaa_aaaa, 32'h1);
    issue_request(KIND_INSERT, 16'sd7, 32'haaaa_aaaa, 32'h5555_5555, 32'h2);
    // negative multiple of the count maps to slot 0
    issue_request(KIND_INSERT, -16'sd7, 32'h0000_ffff, 32'hffff_0000, 32'h3);
    // insert into a full list is refused
    issue_request(KIND_INSERT, 16'sd3, 32'hdead_0001, 32'hdead_0002, 32'hdead_0003);
    issue_request(KIND_GET, -16'sd8, 32'h0, 32'h0, 32'h0);
    issue_request(KIND_GET, 16'sh8000, 32'h0, 32'h0, 32'h0);
    issue_request(KIND_GET, 16'sh7fff, 32'h0, 32'h0, 32'h0);
    issue_request(KIND_GET, -16'sd1, 32'h0, 32'h0, 32'h0);
    issue_request(KIND_SET, 16'sd5, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff);
    issue_request(KIND_GET, 16'sd5, 32'h0, 32'h0, 32'h0);
    // delete down to empty
    issue_request(KIND_DELETE, 16'sh8000, 32'h0, 32'h0, 32'h0);
    issue_request(KIND_DELETE, 16'sh7fff, 32'h0, 32'h0, 32'h0);
    issue_request(KIND_DELETE, -16'sd1, 32'h0, 32'h0, 32'h0);
    issue_request(KIND_DELETE, 16'sd2, 32'h0, 32'h0, 32'h0);
    repeat (4) issue_request(KIND_DELETE, -16'sd3, 32'h0, 32'h0, 32'h0);
    wait_drained();

    // random blocks that fill, drain or churn the list
    for (int blk = 0; blk < 33; blk++) begin
      mix     = mix_t'($urandom_range(0, 2));
      gap_max = ($urandom_range(0, 3) == 0) ? 0 : 19;
      if (blk % 6 == 5) wait_drained();
      for (int j = 0; j < 25; j++) begin
        roll = $urandom_range(0, 99);
        case (mix)
          MIX_GROW:
            k = (roll < 55) ? KIND_INSERT : (roll < 70) ? KIND_DELETE :
                (roll < 85) ? KIND_GET : KIND_SET;
          MIX_SHRINK:
            k = (roll < 15) ? KIND_INSERT : (roll < 60) ? KIND_DELETE :
                (roll < 85) ? KIND_GET : KIND_SET;
          default:
            k = kind_t'(roll % 4);
        endcase
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: pos = 16'($urandom_range(0, 40) - 20);
          6, 7: pos = 16'($urandom);
          8: begin
            case ($urandom_range(0, 3))
              0: pos = 16'sh8000;
              1: pos = 16'sh7fff;
              2: pos = -16'sd1;
              default: pos = 16'sd0;
            endcase
          end
          default: pos = 16'(-($urandom_range(1, 8) * $urandom_range(1, 8)));
        endcase
        issue_request(k, pos, pick_coord(), pick_coord(), pick_coord());
      end
    end

    wait_drained();
    repeat (40) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("tb_top failed");
    $finish;
  end

endmodule
